// File: rtl/core/tg_pkg.sv
package tg_pkg;

    localparam logic [15:0] DEGEN_RECIP_RST = 16'd2560;

    // triangle queue between the front and the back
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // packed so that pos_x sits in the lowest bits
    typedef struct packed {
        logic signed [15:0] tex_v;
        logic signed [15:0] tex_u;
        logic signed [15:0] norm_z;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } vertex_t;

    typedef struct packed {
        vertex_t v2;
        vertex_t v1;
        vertex_t v0;
    } tri_t;

    typedef struct packed {
        logic               last_of_triangle;
        logic               handed_negative;
        logic signed [15:0] tan_z;
        logic signed [15:0] tan_y;
        logic signed [15:0] tan_x;
    } result_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } queue_ctl_t;

endpackage

// File: rtl/core/tg_front.sv
module tg_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  tg_pkg::vertex_t s_vtx,
    output logic            push,
    output tg_pkg::tri_t    push_tri,
    input  logic            full
);
    import tg_pkg::*;

    logic [1:0] phase_reg;
    vertex_t    held_reg [2];
    logic       accept;

    // phase 3 never happens; it completes a triangle like phase 2
    assign s_tready = !phase_reg[1] || !full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && phase_reg[1];
    assign push_tri = '{v2: s_vtx, v1: held_reg[1], v0: held_reg[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
        end else if (accept) begin
            if (phase_reg[1]) begin
                phase_reg <= 2'd0;
            end else begin
                held_reg[phase_reg[0]] <= s_vtx;
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

endmodule

// File: rtl/core/tg_fifo.sv
module tg_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tg_pkg::tri_t        din,
    output logic                full,
    input  tg_pkg::queue_ctl_t  ctl_in,
    output tg_pkg::queue_ctl_t  ctl_out,
    output tg_pkg::tri_t        dout
);
    import tg_pkg::*;

    tri_t               mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_ptr_reg;
    logic [FIFO_PW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] cnt_reg;
    logic               do_pop;

    assign full          = cnt_reg == FIFO_CW'(FIFO_DEPTH);
    assign ctl_out.valid = cnt_reg != '0;
    assign ctl_out.pop   = do_pop;
    assign do_pop        = ctl_in.pop && ctl_out.valid;
    assign dout          = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                mem[wr_ptr_reg] <= din;
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + FIFO_CW'(push) - FIFO_CW'(do_pop);
        end
    end

endmodule

// File: rtl/core/tg_back.sv
module tg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [15:0]        degen_recip,
    input  tg_pkg::queue_ctl_t q_stat,
    output tg_pkg::queue_ctl_t q_req,
    input  tg_pkg::tri_t       in_tri,
    output logic               m_valid,
    input  logic               m_ready,
    output tg_pkg::result_t    m_res
);
    import tg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DET, ST_TB, ST_FIX, ST_SHRINK, ST_DOT, ST_UVEC, ST_HAND,
        ST_NORM, ST_SQ, ST_SQRT, ST_DIVI, ST_DIV, ST_EMIT
    } state_t;

    function automatic logic [1:0] nxt(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    state_t             state_reg;
    logic               half_reg;
    logic [1:0]         idx_reg;
    logic [1:0]         sub_reg;
    logic [1:0]         vtx_reg;
    logic [4:0]         cnt_reg;

    logic signed [16:0] s1_reg, s2_reg, t1_reg, t2_reg;
    logic signed [32:0] q1_reg [3];
    logic signed [32:0] q2_reg [3];
    logic signed [15:0] nrm_reg [3][3];
    logic               det_neg_reg, det_zero_reg;

    logic signed [65:0] acc_reg, prod_reg, hd_reg;
    logic signed [50:0] t_reg [3];
    logic signed [50:0] b_reg [3];
    logic [49:0]        tmag_reg [3];
    logic [49:0]        bmag_reg [3];
    logic               tneg_reg [3];
    logic               bneg_reg [3];
    logic signed [42:0] dot_reg;
    logic signed [41:0] c_reg;
    logic [58:0]        umag_reg [3];
    logic               uneg_reg [3];
    logic [63:0]        sx_reg, sr_reg;
    logic [31:0]        len_reg, rem_reg;
    logic [14:0]        quo_reg;
    logic signed [15:0] o_reg [3];
    logic signed [15:0] lvt_reg [3];
    logic               zero_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic signed [43:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [24:0] tg [3];
    logic signed [20:0] bh [3];
    logic signed [15:0] nk [3];
    logic signed [50:0] tf [3];
    logic signed [50:0] bf [3];
    logic               zero_fix;
    logic               t_big, b_big;
    logic signed [65:0] u_val, sq_sum;
    logic               u_any, u_hi, u_lo;
    logic [63:0]        sq_bb, sq_rb, sr_nx;
    logic               sq_ge;
    logic [44:0]        num;
    logic [32:0]        dv_t;
    logic               dv_ge;
    logic [14:0]        quo_nx;
    logic [1:0]         ia, ib;

    assign q_req.valid = 1'b0;
    assign q_req.pop   = (state_reg == ST_IDLE) && q_stat.valid;
    assign m_valid     = out_valid_reg;
    assign m_res       = out_reg;
    assign mul_p       = mul_a * mul_b;
    assign ia          = nxt(idx_reg);
    assign ib          = nxt(ia);
    assign zero_fix    = det_zero_reg && (degen_recip == 16'd0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tg[i] = tneg_reg[i] ? -$signed({1'b0, tmag_reg[i][23:0]})
                                : $signed({1'b0, tmag_reg[i][23:0]});
            bh[i] = bneg_reg[i] ? -$signed({1'b0, bmag_reg[i][19:0]})
                                : $signed({1'b0, bmag_reg[i][19:0]});
            nk[i] = nrm_reg[vtx_reg][i];
            tf[i] = zero_fix ? '0 : (det_neg_reg ? -t_reg[i] : t_reg[i]);
            bf[i] = zero_fix ? '0 : (det_neg_reg ? -b_reg[i] : b_reg[i]);
        end
        t_big = |{tmag_reg[0][49:24], tmag_reg[1][49:24], tmag_reg[2][49:24]};
        b_big = |{bmag_reg[0][49:20], bmag_reg[1][49:20], bmag_reg[2][49:20]};
        u_any = |{umag_reg[0], umag_reg[1], umag_reg[2]};
        u_hi  = |{umag_reg[0][58:30], umag_reg[1][58:30], umag_reg[2][58:30]};
        u_lo  = !(|{umag_reg[0][58:29], umag_reg[1][58:29], umag_reg[2][58:29]});
        u_val = (66'(tg[idx_reg]) <<< 28) - prod_reg;
        sq_sum = acc_reg + (sub_reg[0] ? (prod_reg <<< 15) : prod_reg);
        // one result bit of the square root per cycle
        sq_bb = 64'd1 << {cnt_reg, 1'b0};
        sq_rb = sr_reg + sq_bb;
        sq_ge = sx_reg >= sq_rb;
        sr_nx = sq_ge ? (sr_reg >> 1) + sq_bb : sr_reg >> 1;
        // rounded numerator; its top part is already below len
        num = {1'b0, umag_reg[idx_reg][29:0], 14'd0} + {14'd0, len_reg[31:1]};
        dv_t = {rem_reg, quo_reg[14]};
        dv_ge = dv_t >= {1'b0, len_reg};
        quo_nx = {quo_reg[13:0], dv_ge};
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DET: begin
                mul_a = sub_reg[0] ? 44'(s2_reg) : 44'(s1_reg);
                mul_b = sub_reg[0] ? 22'(t1_reg) : 22'(t2_reg);
            end
            ST_TB: begin
                case (sub_reg)
                    2'd0: begin mul_a = 44'(q1_reg[idx_reg]); mul_b = 22'(t2_reg); end
                    2'd1: begin mul_a = 44'(q2_reg[idx_reg]); mul_b = 22'(t1_reg); end
                    2'd2: begin mul_a = 44'(q2_reg[idx_reg]); mul_b = 22'(s1_reg); end
                    default: begin mul_a = 44'(q1_reg[idx_reg]); mul_b = 22'(s2_reg); end
                endcase
            end
            ST_DOT: begin
                mul_a = 44'(tg[idx_reg]);
                mul_b = 22'(nk[idx_reg]);
            end
            ST_UVEC: begin
                mul_a = 44'(dot_reg);
                mul_b = 22'(nk[idx_reg]);
            end
            ST_HAND: begin
                case (sub_reg)
                    2'd0: begin mul_a = 44'(tg[ib]); mul_b = 22'(nk[ia]); end
                    2'd1: begin mul_a = 44'(tg[ia]); mul_b = 22'(nk[ib]); end
                    default: begin mul_a = 44'(c_reg); mul_b = 22'(bh[idx_reg]); end
                endcase
            end
            ST_SQ: begin
                mul_a = $signed({14'd0, umag_reg[idx_reg][29:0]});
                mul_b = sub_reg[0] ? $signed({7'd0, umag_reg[idx_reg][29:15]})
                                   : $signed({7'd0, umag_reg[idx_reg][14:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) lvt_reg[i] <= '0;
        end else begin
            prod_reg <= mul_p;
            if (state_reg == ST_EMIT && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_stat.valid) begin
                        s1_reg <= 17'(in_tri.v1.tex_u) - 17'(in_tri.v0.tex_u);
                        s2_reg <= 17'(in_tri.v2.tex_u) - 17'(in_tri.v0.tex_u);
                        t1_reg <= 17'(in_tri.v1.tex_v) - 17'(in_tri.v0.tex_v);
                        t2_reg <= 17'(in_tri.v2.tex_v) - 17'(in_tri.v0.tex_v);
                        q1_reg[0] <= 33'(in_tri.v1.pos_x) - 33'(in_tri.v0.pos_x);
                        q1_reg[1] <= 33'(in_tri.v1.pos_y) - 33'(in_tri.v0.pos_y);
                        q1_reg[2] <= 33'(in_tri.v1.pos_z) - 33'(in_tri.v0.pos_z);
                        q2_reg[0] <= 33'(in_tri.v2.pos_x) - 33'(in_tri.v0.pos_x);
                        q2_reg[1] <= 33'(in_tri.v2.pos_y) - 33'(in_tri.v0.pos_y);
                        q2_reg[2] <= 33'(in_tri.v2.pos_z) - 33'(in_tri.v0.pos_z);
                        nrm_reg[0] <= '{in_tri.v0.norm_x, in_tri.v0.norm_y, in_tri.v0.norm_z};
                        nrm_reg[1] <= '{in_tri.v1.norm_x, in_tri.v1.norm_y, in_tri.v1.norm_z};
                        nrm_reg[2] <= '{in_tri.v2.norm_x, in_tri.v2.norm_y, in_tri.v2.norm_z};
                        idx_reg   <= 2'd0;
                        sub_reg   <= 2'd0;
                        half_reg  <= 1'b0;
                        state_reg <= ST_DET;
                    end
                end
                ST_DET: begin
                    half_reg <= !half_reg;
                    if (half_reg) begin
                        if (!sub_reg[0]) begin
                            acc_reg <= prod_reg;
                            sub_reg <= 2'd1;
                        end else begin
                            det_neg_reg  <= (acc_reg - prod_reg) < 0;
                            det_zero_reg <= acc_reg == prod_reg;
                            sub_reg      <= 2'd0;
                            state_reg    <= ST_TB;
                        end
                    end
                end
                ST_TB: begin
                    half_reg <= !half_reg;
                    if (half_reg) begin
                        sub_reg <= sub_reg + 2'd1;
                        case (sub_reg)
                            2'd1: t_reg[idx_reg] <= 51'(acc_reg - prod_reg);
                            2'd3: begin
                                b_reg[idx_reg] <= 51'(acc_reg - prod_reg);
                                idx_reg <= nxt(idx_reg);
                                if (idx_reg == 2'd2) state_reg <= ST_FIX;
                            end
                            default: acc_reg <= prod_reg;
                        endcase
                    end
                end
                ST_FIX: begin
                    for (int i = 0; i < 3; i++) begin
                        tneg_reg[i] <= tf[i][50];
                        bneg_reg[i] <= bf[i][50];
                        tmag_reg[i] <= tf[i][50] ? 50'(-tf[i]) : 50'(tf[i]);
                        bmag_reg[i] <= bf[i][50] ? 50'(-bf[i]) : 50'(bf[i]);
                    end
                    state_reg <= ST_SHRINK;
                end
                ST_SHRINK: begin
                    for (int i = 0; i < 3; i++) begin
                        if (t_big) tmag_reg[i] <= tmag_reg[i] >> 1;
                        if (b_big) bmag_reg[i] <= bmag_reg[i] >> 1;
                    end
                    if (!t_big && !b_big) begin
                        vtx_reg   <= 2'd0;
                        idx_reg   <= 2'd0;
                        state_reg <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    half_reg <= !half_reg;
                    if (half_reg) begin
                        acc_reg <= ((idx_reg == 2'd0) ? 66'sd0 : acc_reg) + prod_reg;
                        idx_reg <= nxt(idx_reg);
                        if (idx_reg == 2'd2) begin
                            dot_reg   <= 43'(acc_reg + prod_reg);
                            state_reg <= ST_UVEC;
                        end
                    end
                end
                ST_UVEC: begin
                    half_reg <= !half_reg;
                    if (half_reg) begin
                        uneg_reg[idx_reg] <= u_val[65];
                        umag_reg[idx_reg] <= u_val[65] ? 59'(-u_val) : 59'(u_val);
                        idx_reg <= nxt(idx_reg);
                        if (idx_reg == 2'd2) begin
                            hd_reg    <= '0;
                            sub_reg   <= 2'd0;
                            state_reg <= ST_HAND;
                        end
                    end
                end
                ST_HAND: begin
                    half_reg <= !half_reg;
                    if (half_reg) begin
                        case (sub_reg)
                            2'd0: begin
                                acc_reg <= prod_reg;
                                sub_reg <= 2'd1;
                            end
                            2'd1: begin
                                c_reg   <= 42'(acc_reg - prod_reg);
                                sub_reg <= 2'd2;
                            end
                            default: begin
                                hd_reg  <= hd_reg + prod_reg;
                                sub_reg <= 2'd0;
                                idx_reg <= nxt(idx_reg);
                                if (idx_reg == 2'd2) state_reg <= ST_NORM;
                            end
                        endcase
                    end
                end
                ST_NORM: begin
                    if (!u_any) begin
                        zero_reg  <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else if (u_hi) begin
                        for (int i = 0; i < 3; i++) umag_reg[i] <= umag_reg[i] >> 1;
                    end else if (u_lo) begin
                        for (int i = 0; i < 3; i++) umag_reg[i] <= umag_reg[i] << 1;
                    end else begin
                        zero_reg  <= 1'b0;
                        acc_reg   <= '0;
                        sub_reg   <= 2'd0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    half_reg <= !half_reg;
                    if (half_reg) begin
                        acc_reg <= sq_sum;
                        sub_reg <= {1'b0, !sub_reg[0]};
                        if (sub_reg[0]) begin
                            idx_reg <= nxt(idx_reg);
                            if (idx_reg == 2'd2) begin
                                sx_reg    <= sq_sum[63:0];
                                sr_reg    <= '0;
                                cnt_reg   <= 5'd31;
                                state_reg <= ST_SQRT;
                            end
                        end
                    end
                end
                ST_SQRT: begin
                    if (sq_ge) sx_reg <= sx_reg - sq_rb;
                    sr_reg  <= sr_nx;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        len_reg   <= sr_nx[31:0];
                        idx_reg   <= 2'd0;
                        state_reg <= ST_DIVI;
                    end
                end
                ST_DIVI: begin
                    rem_reg   <= 32'(num[44:15]);
                    quo_reg   <= num[14:0];
                    cnt_reg   <= 5'd14;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= dv_ge ? 32'(dv_t - {1'b0, len_reg}) : dv_t[31:0];
                    quo_reg <= quo_nx;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        o_reg[idx_reg] <= uneg_reg[idx_reg] ? -$signed({1'b0, quo_nx})
                                                            : $signed({1'b0, quo_nx});
                        idx_reg   <= nxt(idx_reg);
                        state_reg <= (idx_reg == 2'd2) ? ST_EMIT : ST_DIVI;
                    end
                end
                ST_EMIT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg.tan_x <= zero_reg ? lvt_reg[0] : o_reg[0];
                        out_reg.tan_y <= zero_reg ? lvt_reg[1] : o_reg[1];
                        out_reg.tan_z <= zero_reg ? lvt_reg[2] : o_reg[2];
                        out_reg.handed_negative  <= hd_reg[65];
                        out_reg.last_of_triangle <= vtx_reg == 2'd2;
                        if (!zero_reg) begin
                            for (int i = 0; i < 3; i++) lvt_reg[i] <= o_reg[i];
                        end
                        idx_reg <= 2'd0;
                        vtx_reg <= nxt(vtx_reg);
                        state_reg <= (vtx_reg == 2'd2) ? ST_IDLE : ST_DOT;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/triangle_tangent_generator.sv
// channel  | dir | handshake           | payload
// s_       | in  | s_tvalid / s_tready | vertex: position, normal, texcoord
// m_       | out | m_tvalid / m_tready | tangent, handedness (tuser), tlast
// cfg_     | in  | cfg_valid/cfg_ready | degenerate reciprocal, Q8.8
//
// A vertex is taken on each s_ handshake; the first two are held. The third completes a
// triangle, which goes into a two-deep queue. The back end shares one 44x22
// multiplier and a bit-serial square root and divider. Triangle setup time is set by
// the shifts that bring T and B into range; each vertex then runs the 32-step square
// root, three divides and the normalizing shifts, with the root and divides skipped
// when the tangent comes out zero. Reset is synchronous, active low. Output stalls hold
// the back end only; the front keeps taking vertices while the queue has room.
module triangle_tangent_generator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tan_x, tan_y, tan_z
    output logic [47:0]  m_tdata,
    // handed_negative
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);
    import tg_pkg::*;

    logic [15:0] recip_reg;
    logic        push, full;
    tri_t        push_tri, head_tri;
    queue_ctl_t  q_stat, q_req;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_reg <= DEGEN_RECIP_RST;
        end else if (cfg_valid) begin
            recip_reg <= cfg_data;
        end
    end

    tg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_vtx    (vertex_t'(s_tdata)),
        .push     (push),
        .push_tri (push_tri),
        .full     (full)
    );

    tg_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_tri),
        .full    (full),
        .ctl_in  (q_req),
        .ctl_out (q_stat),
        .dout    (head_tri)
    );

    tg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .degen_recip (recip_reg),
        .q_stat      (q_stat),
        .q_req       (q_req),
        .in_tri      (head_tri),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_res       (res)
    );

    assign m_tdata = {res.tan_z, res.tan_y, res.tan_x};
    assign m_tuser = res.handed_negative;
    assign m_tlast = res.last_of_triangle;

endmodule

// File: dv/tb_triangle_tangent_generator.sv
module tb_triangle_tangent_generator;
    import tg_pkg::*;

    typedef struct packed {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic               neg;
        logic               last;
    } tangent_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;

    triangle_tangent_generator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    vertex_t  vertex_q[$];
    tangent_t tangent_q[$];
    int       errors;
    int       n_sent;
    int       n_tris;
    int       n_degen;
    longint   cycles;
    int       send_gap;
    bit       hold_sender;

    // predictor state
    logic [15:0]  recip;
    int           phase;
    vertex_t      held [2];
    longint       last_tan [3];

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void scale_below(ref longint v[3], input int bits);
        longint mx;
        int sh;
        mx = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) if (magnitude(v[i]) > mx) mx = magnitude(v[i]);
        while ((mx >>> sh) >= (64'sd1 <<< bits)) sh++;
        for (int i = 0; i < 3; i++)
            v[i] = v[i] < 0 ? -(magnitude(v[i]) >>> sh) : (magnitude(v[i]) >>> sh);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in Q2.14; returns 0 when u is all zero
    function automatic bit to_unit(input longint u[3], output longint o[3]);
        longint unsigned mg[3], mx, sum, len;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = magnitude(u[i]);
            if (mg[i] > mx) mx = mg[i];
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mg[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mg[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += mg[i] * mg[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            longint q;
            q = longint'((mg[i] * 16384 + len / 2) / len);
            o[i] = u[i] < 0 ? -q : q;
        end
        return 1;
    endfunction

    task automatic predict_tangents(input vertex_t v);
        vertex_t tri_v[3];
        longint  s1, s2, t1, t2, det, dot, hd;
        longint  q1[3], q2[3], tg[3], th[3], bh[3], u[3], c[3], o[3], nrm[3];
        tangent_t r;
        if (phase < 2) begin
            held[phase] = v;
            phase++;
            return;
        end
        phase = 0;
        tri_v[0] = held[0];
        tri_v[1] = held[1];
        tri_v[2] = v;
        s1 = longint'(tri_v[1].tex_u) - tri_v[0].tex_u;
        s2 = longint'(tri_v[2].tex_u) - tri_v[0].tex_u;
        t1 = longint'(tri_v[1].tex_v) - tri_v[0].tex_v;
        t2 = longint'(tri_v[2].tex_v) - tri_v[0].tex_v;
        det = s1 * t2 - s2 * t1;
        if (det == 0) n_degen++;
        q1[0] = longint'(tri_v[1].pos_x) - tri_v[0].pos_x;
        q1[1] = longint'(tri_v[1].pos_y) - tri_v[0].pos_y;
        q1[2] = longint'(tri_v[1].pos_z) - tri_v[0].pos_z;
        q2[0] = longint'(tri_v[2].pos_x) - tri_v[0].pos_x;
        q2[1] = longint'(tri_v[2].pos_y) - tri_v[0].pos_y;
        q2[2] = longint'(tri_v[2].pos_z) - tri_v[0].pos_z;
        for (int i = 0; i < 3; i++) begin
            tg[i] = t2 * q1[i] - t1 * q2[i];
            bh[i] = s1 * q2[i] - s2 * q1[i];
            if (det == 0 && recip == 0) begin
                tg[i] = 0;
                bh[i] = 0;
            end else if (det < 0) begin
                tg[i] = -tg[i];
                bh[i] = -bh[i];
            end
        end
        scale_below(tg, 24);
        scale_below(bh, 20);
        th = tg;
        for (int k = 0; k < 3; k++) begin
            nrm[0] = tri_v[k].norm_x;
            nrm[1] = tri_v[k].norm_y;
            nrm[2] = tri_v[k].norm_z;
            dot = nrm[0] * tg[0] + nrm[1] * tg[1] + nrm[2] * tg[2];
            for (int i = 0; i < 3; i++) u[i] = tg[i] * (64'sd1 <<< 28) - dot * nrm[i];
            c[0] = nrm[1] * th[2] - nrm[2] * th[1];
            c[1] = nrm[2] * th[0] - nrm[0] * th[2];
            c[2] = nrm[0] * th[1] - nrm[1] * th[0];
            hd = c[0] * bh[0] + c[1] * bh[1] + c[2] * bh[2];
            if (to_unit(u, o)) last_tan = o;
            else o = last_tan;
            r.tx = o[0][15:0];
            r.ty = o[1][15:0];
            r.tz = o[2][15:0];
            r.neg = hd < 0;
            r.last = k == 2;
            tangent_q = {tangent_q, r};
        end
        n_tris++;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("error: %s got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= '0;
            send_gap <= 0;
        end else begin
            logic busy;
            busy = s_tvalid && !s_tready;
            if (!busy) begin
                if (s_tvalid) begin
                    predict_tangents(s_tdata);
                    n_sent++;
                    void'(vertex_q.pop_front());
                end
                if (vertex_q.size() != 0 && !hold_sender && send_gap == 0
                        && !(s_tvalid && vertex_q.size() == 0)) begin
                    s_tvalid <= 1;
                    s_tdata <= vertex_q[0];
                    send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                              : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
                end else begin
                    s_tvalid <= 0;
                    if (send_gap != 0) send_gap <= send_gap - 1;
                end
            end
        end
    end

    // monitor and stall generator
    int stall;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                tangent_t want;
                if (tangent_q.size() == 0) begin
                    report_mismatch("unexpected tangent", m_tdata, 0);
                end else begin
                    want = tangent_q.pop_front();
                    if (m_tdata[15:0] !== want.tx) report_mismatch("tan_x", m_tdata[15:0], want.tx);
                    if (m_tdata[31:16] !== want.ty)
                        report_mismatch("tan_y", m_tdata[31:16], want.ty);
                    if (m_tdata[47:32] !== want.tz)
                        report_mismatch("tan_z", m_tdata[47:32], want.tz);
                    if (m_tuser !== want.neg) report_mismatch("handed_negative", m_tuser, want.neg);
                    if (m_tlast !== want.last) report_mismatch("tlast", m_tlast, want.last);
                end
            end
            if (stall != 0) begin
                stall <= stall - 1;
                m_tready <= 0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("triangle_tangent_generator: mismatch");
            $finish;
        end
    end

    function automatic vertex_t random_vertex(input int shape);
        vertex_t v;
        v = vertex_t'(176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        if (shape == 0) begin
            // moderate positions and roughly unit normals
            v.pos_x = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            v.pos_y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            v.pos_z = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            v.norm_x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            v.norm_y = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            v.norm_z = 16'sd16384;
            v.tex_u = 16'($urandom_range(0, 16384));
            v.tex_v = 16'($urandom_range(0, 16384));
        end
        return v;
    endfunction

    task automatic add_tri(input vertex_t a, input vertex_t b, input vertex_t c);
        vertex_q = {vertex_q, a, b, c};
    endtask

    task automatic wait_drained();
        while (vertex_q.size() != 0 || s_tvalid || tangent_q.size() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
    endtask

    task automatic write_recip(input logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        recip = value;
        cfg_valid <= 0;
    endtask

    initial begin
        vertex_t a, b, c;
        aresetn = 0;
        cfg_valid = 0;
        cfg_data = '0;
        hold_sender = 0;
        recip = DEGEN_RECIP_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // directed: plain right-handed triangle
        a = '0; b = '0; c = '0;
        a.norm_z = 16'sd16384; b.norm_z = 16'sd16384; c.norm_z = 16'sd16384;
        b.pos_x = 32'sh10000; c.pos_y = 32'sh10000;
        b.tex_u = 16'sd16384; c.tex_v = 16'sd16384;
        add_tri(a, b, c);
        // mirrored texcoords, negative handedness
        b.tex_u = -16'sd16384;
        add_tri(a, b, c);
        // degenerate texcoords with default reciprocal
        b.tex_u = '0; c.tex_v = '0;
        add_tri(a, b, c);
        // normal parallel to tangent: zero u reuses last tangent
        b.tex_u = 16'sd16384; c.tex_v = 16'sd16384;
        a.norm_z = '0; a.norm_x = 16'sd16384;
        add_tri(a, b, c);
        // field extremes
        a = vertex_t'(176'({6{32'h8000_0000}}));
        b = vertex_t'(176'({6{32'h7fff_ffff}}));
        c = '1;
        add_tri(a, b, c);
        a = '1; b = '0; c = vertex_t'(176'({6{32'h8000_7fff}}));
        add_tri(a, b, c);
        wait_drained();

        // zero reciprocal zeroes T and B on degenerate triangles
        write_recip(16'h0000);
        a = random_vertex(0); b = a; c = a;
        add_tri(a, b, c);
        for (int i = 0; i < 8; i++)
            add_tri(random_vertex(0), random_vertex(0), random_vertex(0));
        wait_drained();
        write_recip(16'hffff);
        add_tri(a, b, c);
        for (int i = 0; i < 8; i++)
            add_tri(random_vertex(0), random_vertex(0), random_vertex(0));
        // mid-stream, pause until everything expected has come out
        while (vertex_q.size() > 12) @(posedge aclk);
        hold_sender = 1;
        while (s_tvalid || tangent_q.size() != 0) @(posedge aclk);
        hold_sender = 0;
        wait_drained();
        write_recip(16'($urandom));

        for (int i = 0; i < 26; i++) begin
            int pick;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                add_tri(random_vertex(0), random_vertex(0), random_vertex(0));
            end else if (pick < 8) begin
                add_tri(random_vertex(1), random_vertex(1), random_vertex(1));
            end else begin
                // shared texcoords make a degenerate triangle
                a = random_vertex(0); b = random_vertex(0); c = random_vertex(0);
                b.tex_u = a.tex_u; b.tex_v = a.tex_v;
                add_tri(a, b, c);
            end
        end
        wait_drained();

        $display("%0d vertices, %0d triangles (%0d with zero determinant), last recip %0h",
                 n_sent, n_tris, n_degen, recip);
        $display("covered reciprocal extremes, mirrored uv, zero tangents and full-range fields");
        if (errors == 0) begin
            $display("triangle_tangent_generator: match");
        end else begin
            $display("triangle_tangent_generator: mismatch");
        end
        $finish;
    end
endmodule
